/* rtl/ptc_pkg.sv */
// Shared types and constants of the compact target check pipeline.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ptc_pkg;

   localparam int WORD_WIDTH     = 64;
   localparam int HASH_WORDS     = 4;
   localparam int HASH_WIDTH     = WORD_WIDTH * HASH_WORDS;
   localparam int COMPACT_WIDTH  = 32;
   localparam int EXP_WIDTH      = 8;
   localparam int MANT_WIDTH     = 23;
   localparam int SHIFT_WIDTH    = 5;
   localparam int STATUS_WIDTH   = 3;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 64;

   localparam logic [EXP_WIDTH-1:0]  EXP_BIAS     = 8'd3;
   localparam logic [EXP_WIDTH-1:0]  EXP_MAX      = 8'd34;
   localparam logic [EXP_WIDTH-1:0]  EXP_MAX_BYTE = 8'd33;
   localparam logic [EXP_WIDTH-1:0]  EXP_MAX_HALF = 8'd32;
   localparam logic [MANT_WIDTH-1:0] MANT_BYTE    = 23'h0000ff;
   localparam logic [MANT_WIDTH-1:0] MANT_HALF    = 23'h00ffff;

   localparam logic [WORD_WIDTH-1:0] LIMIT_RESET = '1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_PASS        = 3'd0,
      ST_NEGATIVE    = 3'd1,
      ST_ZERO        = 3'd2,
      ST_OVERFLOW    = 3'd3,
      ST_ABOVE_LIMIT = 3'd4,
      ST_HASH_HIGH   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REG_LIMIT_0 = 2'd0,
      REG_LIMIT_1 = 2'd1,
      REG_LIMIT_2 = 2'd2,
      REG_LIMIT_3 = 2'd3
   } reg_index_type;

   typedef logic [HASH_WORDS-1:0][WORD_WIDTH-1:0] wide_type;

   typedef struct packed {
      wide_type                hash;
      logic [MANT_WIDTH-1:0]   mant;
      logic [SHIFT_WIDTH-1:0]  byte_shift;
      status_type              status;
   } dec_type;

   typedef struct packed {
      wide_type   hash;
      wide_type   target;
      status_type status;
   } exp_type;

   typedef struct packed {
      logic [HASH_WORDS-1:0] hash_gt;
      logic [HASH_WORDS-1:0] hash_eq;
      logic [HASH_WORDS-1:0] lim_gt;
      logic [HASH_WORDS-1:0] lim_eq;
      status_type            status;
   } cmp_type;

endpackage

`default_nettype wire

/* rtl/ptc_req_if.sv */
// Input channel of the target check: hash words and compact target.
// Depends on ptc_pkg for field widths.
`default_nettype none

interface ptc_req_if import ptc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [WORD_WIDTH-1:0]    hash_word_0;
   logic [WORD_WIDTH-1:0]    hash_word_1;
   logic [WORD_WIDTH-1:0]    hash_word_2;
   logic [WORD_WIDTH-1:0]    hash_word_3;
   logic [COMPACT_WIDTH-1:0] compact_target;

   modport source (output valid, hash_word_0, hash_word_1, hash_word_2, hash_word_3,
                   compact_target, input ready);
   modport sink   (input valid, hash_word_0, hash_word_1, hash_word_2, hash_word_3,
                   compact_target, output ready);
endinterface

`default_nettype wire

/* rtl/ptc_rsp_if.sv */
// Result channel of the target check: pass flag and status code.
// Depends on ptc_pkg for field widths.
`default_nettype none

interface ptc_rsp_if import ptc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    pass;
   logic [STATUS_WIDTH-1:0] status;

   modport source (output valid, pass, status, input ready);
   modport sink   (input valid, pass, status, output ready);
endinterface

`default_nettype wire

/* rtl/ptc_decode.sv */
// Stage 1: split the compact target, form the effective mantissa and the
// early rejections (negative, zero, overflow). Depends on ptc_pkg.
`default_nettype none

module ptc_decode import ptc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  wide_type                 in_hash,
   input  logic [COMPACT_WIDTH-1:0] in_compact,
   output logic                     out_valid,
   input  logic                     out_ready,
   output dec_type                  out_data
);

   logic                  valid_ff, valid_in;
   dec_type               data_ff, data_in;
   logic [EXP_WIDTH-1:0]  exponent;
   logic                  sign;
   logic [MANT_WIDTH-1:0] raw_mant, eff_mant;
   logic [EXP_WIDTH-1:0]  shift_full;
   logic                  overflow;

   assign exponent = in_compact[COMPACT_WIDTH-1 -: EXP_WIDTH];
   assign sign     = in_compact[MANT_WIDTH];
   assign raw_mant = in_compact[MANT_WIDTH-1:0];

   always_comb begin
      case (exponent)
         8'd0:    eff_mant = '0;
         8'd1:    eff_mant = raw_mant >> 16;
         8'd2:    eff_mant = raw_mant >> 8;
         default: eff_mant = raw_mant;
      endcase
   end

   assign overflow   = (exponent > EXP_MAX)
                    || ((eff_mant > MANT_BYTE) && (exponent > EXP_MAX_BYTE))
                    || ((eff_mant > MANT_HALF) && (exponent > EXP_MAX_HALF));
   assign shift_full = (exponent > EXP_BIAS) ? (exponent - EXP_BIAS) : '0;

   always_comb begin
      data_in            = data_ff;
      valid_in           = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in.hash       = in_hash;
            data_in.mant       = eff_mant;
            data_in.byte_shift = shift_full[SHIFT_WIDTH-1:0];
            if (eff_mant != '0 && sign)
               data_in.status = ST_NEGATIVE;
            else if (eff_mant == '0)
               data_in.status = ST_ZERO;
            else if (overflow)
               data_in.status = ST_OVERFLOW;
            else
               data_in.status = ST_PASS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/ptc_expand.sv */
// Stage 2: expand the effective mantissa into the 256-bit target by a
// byte-granular barrel shift. Depends on ptc_pkg.
`default_nettype none

module ptc_expand import ptc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  dec_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output exp_type out_data
);

   logic                        valid_ff, valid_in;
   exp_type                     data_ff, data_in;
   logic [HASH_WIDTH-1:0]       target;
   logic [SHIFT_WIDTH+2:0]      bit_shift;

   assign bit_shift = {in_data.byte_shift, 3'b000};
   assign target    = HASH_WIDTH'(in_data.mant) << bit_shift;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in.hash   = in_data.hash;
            data_in.target = target;
            data_in.status = in_data.status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/ptc_compare.sv */
// Stages 3 and 4: per-word compares of target against limit and hash
// against target, then the ordered merge into the final status. Depends on ptc_pkg.
`default_nettype none

module ptc_compare import ptc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  wide_type                limit,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  exp_type                 in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic                    out_pass,
   output logic [STATUS_WIDTH-1:0] out_status
);

   logic       cmp_valid_ff, cmp_valid_in, cmp_ready;
   cmp_type    cmp_ff, cmp_in;
   logic       res_valid_ff, res_valid_in;
   status_type res_ff, res_in;
   logic       lim_greater, hash_greater;
   status_type merged;

   always_comb begin
      cmp_in       = cmp_ff;
      cmp_valid_in = cmp_valid_ff;
      if (in_ready) begin
         cmp_valid_in = in_valid;
         if (in_valid) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
               cmp_in.lim_gt[i]  = in_data.target[i] > limit[i];
               cmp_in.lim_eq[i]  = in_data.target[i] == limit[i];
               cmp_in.hash_gt[i] = in_data.hash[i] > in_data.target[i];
               cmp_in.hash_eq[i] = in_data.hash[i] == in_data.target[i];
            end
            cmp_in.status = in_data.status;
         end
      end
   end

   always_comb begin
      lim_greater  = 1'b0;
      hash_greater = 1'b0;
      for (int i = 0; i < HASH_WORDS; i++) begin
         lim_greater  = cmp_ff.lim_gt[i] || (cmp_ff.lim_eq[i] && lim_greater);
         hash_greater = cmp_ff.hash_gt[i] || (cmp_ff.hash_eq[i] && hash_greater);
      end
      if (cmp_ff.status != ST_PASS)
         merged = cmp_ff.status;
      else if (lim_greater)
         merged = ST_ABOVE_LIMIT;
      else if (hash_greater)
         merged = ST_HASH_HIGH;
      else
         merged = ST_PASS;
   end

   always_comb begin
      res_in       = res_ff;
      res_valid_in = res_valid_ff;
      if (cmp_ready) begin
         res_valid_in = cmp_valid_ff;
         if (cmp_valid_ff)
            res_in = merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmp_valid_in;
         res_valid_ff <= res_valid_in;
      end
      cmp_ff <= cmp_in;
      res_ff <= res_in;
   end

   assign cmp_ready  = !res_valid_ff || out_ready;
   assign in_ready   = !cmp_valid_ff || cmp_ready;
   assign out_valid  = res_valid_ff;
   assign out_status = res_ff;
   assign out_pass   = (res_ff == ST_PASS);

endmodule

`default_nettype wire

/* rtl/pow_target_check_top.sv */
// Top level of the compact target check: limit registers on the APB-style
// port and the four-stage pipeline. Depends on ptc_pkg, ptc_req_if, ptc_rsp_if,
// ptc_decode, ptc_expand and ptc_compare.
//
//   channel   direction  handshake         contents
//   req       in         valid/ready       hash_word_0..3, compact_target
//   rsp       out        valid/ready       pass, status
//   csr       in         psel/penable      limit_word_0..3 at 8*i, 64-bit data
//
// An accepted item passes four registered stages before its result is valid:
// decode, target expansion, per-word compare, status merge.
// One item per cycle is sustained while rsp is ready; each stage holds a valid bit and refills
// when it is empty or its successor takes its item.
// A stalled rsp holds the last stage; earlier stages keep filling bubbles.
// Synchronous reset empties the pipeline and sets the limit to all ones.
`default_nettype none

module pow_target_check_top import ptc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   ptc_req_if.sink                   req,
   ptc_rsp_if.source                 rsp,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   wide_type      limit_ff, limit_in;
   reg_index_type csr_index;
   logic          csr_write;
   logic          dec_valid, dec_ready, exp_valid, exp_ready;
   dec_type       dec_data;
   exp_type       exp_data;
   wide_type      req_hash;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_WIDTH-1:3]);
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = limit_ff[csr_index];

   always_comb begin
      limit_in = limit_ff;
      if (csr_write)
         limit_in[csr_index] = pwdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= {HASH_WORDS{LIMIT_RESET}};
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign req_hash = {req.hash_word_3, req.hash_word_2, req.hash_word_1, req.hash_word_0};

   ptc_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .in_hash    (req_hash),
      .in_compact (req.compact_target),
      .out_valid  (dec_valid),
      .out_ready  (dec_ready),
      .out_data   (dec_data)
   );

   ptc_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (exp_valid),
      .out_ready (exp_ready),
      .out_data  (exp_data)
   );

   ptc_compare u_compare (
      .clock      (clock),
      .reset      (reset),
      .limit      (limit_ff),
      .in_valid   (exp_valid),
      .in_ready   (exp_ready),
      .in_data    (exp_data),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_pass   (rsp.pass),
      .out_status (rsp.status)
   );

   a_pass_status: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.pass == (rsp.status == ST_PASS)))
      else $error("pass flag disagrees with status");

   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp.ready |-> req.ready)
      else $error("pipeline blocks input while output drains");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> limit_ff[$past(csr_index)] == $past(pwdata))
      else $error("limit register not updated by write");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

/* verif/tb_pow_target_check_top.sv */
// Self-checking bench for pow_target_check_top: compact target expansion,
// limit check and hash compare, with random idling on both channels.
// Depends on ptc_pkg, ptc_req_if, ptc_rsp_if and the block's RTL.
`timescale 1ns / 1ps

module tb_pow_target_check_top;
   import ptc_pkg::*;

   localparam int PIPE_LATENCY = 4;
   localparam int LONG_HOLD    = 80;
   localparam int RUN_LIMIT    = 400000;

   class target_scoreboard;
      typedef struct {
         logic       pass;
         status_type status;
      } verdict_type;

      wide_type    limit_copy;
      verdict_type pending_verdicts[$];
      int          mismatches;
      int          results_checked;
      int          items_noted;
      int          status_seen[6];

      function new();
         limit_copy = '1;
         mismatches = 0;
         results_checked = 0;
         items_noted = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void set_limit(int index, logic [WORD_WIDTH-1:0] value);
         limit_copy[index] = value;
      endfunction

      function int pending();
         return pending_verdicts.size();
      endfunction

      function wide_type expand_target(logic [COMPACT_WIDTH-1:0] compact);
         int                    exponent;
         logic [MANT_WIDTH-1:0] mant;
         logic [HASH_WIDTH-1:0] target;
         exponent = int'(compact[31:24]);
         mant = compact[22:0];
         if (exponent <= 3) mant = mant >> (8 * (3 - exponent));
         target = HASH_WIDTH'(mant);
         if (exponent > 3) target = target << (8 * (exponent - 3));
         return target;
      endfunction

      function status_type judge_hash(wide_type hash, logic [COMPACT_WIDTH-1:0] compact);
         int                    exponent;
         logic [MANT_WIDTH-1:0] mant;
         wide_type              target;
         exponent = int'(compact[31:24]);
         mant = compact[22:0];
         if (exponent <= 3) mant = mant >> (8 * (3 - exponent));
         if (mant != '0 && compact[23]) return ST_NEGATIVE;
         if (mant == '0) return ST_ZERO;
         if (exponent > 34 || (mant > 23'hff && exponent > 33) ||
             (mant > 23'hffff && exponent > 32))
            return ST_OVERFLOW;
         target = expand_target(compact);
         if (target > limit_copy) return ST_ABOVE_LIMIT;
         if (hash > target) return ST_HASH_HIGH;
         return ST_PASS;
      endfunction

      function void note_request(wide_type hash, logic [COMPACT_WIDTH-1:0] compact);
         verdict_type verdict;
         verdict.status = judge_hash(hash, compact);
         verdict.pass = (verdict.status == ST_PASS);
         pending_verdicts.push_back(verdict);
         items_noted++;
      endfunction

      task report(string msg);
         $display("%0t ns mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_result(logic pass, logic [STATUS_WIDTH-1:0] status);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            report($sformatf("result pass=%0d status=%0d with no item outstanding",
                             pass, status));
         end else begin
            want = pending_verdicts.pop_front();
            results_checked++;
            status_seen[want.status]++;
            if (pass !== want.pass)
               report($sformatf("pass got %0d expected %0d", pass, want.pass));
            if (status !== want.status)
               report($sformatf("status got %0d expected %0d", status, want.status));
         end
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   ptc_req_if req_ch ();
   ptc_rsp_if rsp_ch ();

   pow_target_check_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   target_scoreboard sb = new();

   int   cycle_count = 0;
   int   hold_asked = 0;
   int   hold_served = 0;
   int   rush_left = 0;
   int   stall_left = 0;
   int   limit_settings = 1;
   logic calm = 1'b0;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** pow_target_check_top: FAILED **");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic wide_type random_wide();
      wide_type value;
      for (int i = 0; i < HASH_WORDS; i++) value[i] = {$urandom, $urandom};
      return value;
   endfunction

   // result side: random back-pressure, plus one long hold on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            hold_served++;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (calm) begin
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.pass, rsp_ch.status);
      end
   end

   task automatic offer_item(wide_type hash, logic [COMPACT_WIDTH-1:0] compact);
      int gap;
      gap = (rush_left > 0 || calm) ? 0 : pick_gap();
      if (rush_left > 0) rush_left--;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.hash_word_0    <= hash[0];
      req_ch.hash_word_1    <= hash[1];
      req_ch.hash_word_2    <= hash[2];
      req_ch.hash_word_3    <= hash[3];
      req_ch.compact_target <= compact;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_request(hash, compact);
   endtask

   task automatic offer_random_item();
      logic [EXP_WIDTH-1:0]     exponent;
      logic [MANT_WIDTH-1:0]    mant;
      logic [COMPACT_WIDTH-1:0] compact;
      wide_type                 target;
      wide_type                 hash;
      int                       bits;
      if ($urandom_range(0, 99) < 75) begin
         exponent = EXP_WIDTH'($urandom_range(0, 34));
         bits = $urandom_range(1, 23);
         mant = MANT_WIDTH'($urandom) & MANT_WIDTH'((32'd1 << bits) - 1);
         if (exponent == 8'd34 && $urandom_range(0, 3) != 0) mant &= MANT_BYTE;
         if (exponent == 8'd33 && $urandom_range(0, 3) != 0) mant &= MANT_HALF;
         compact = {exponent, ($urandom_range(0, 15) == 0), mant};
      end else begin
         compact = $urandom;
      end
      target = sb.expand_target(compact);
      case ($urandom_range(0, 9))
         0: hash = target;
         1: hash = target + HASH_WIDTH'($urandom_range(1, 3));
         2: hash = target - HASH_WIDTH'($urandom_range(1, 3));
         3, 4: hash = target >> $urandom_range(0, 64);
         5, 6: hash = random_wide();
         7: hash = random_wide() >> $urandom_range(0, 255);
         8: hash = '0;
         default: hash = '1;
      endcase
      offer_item(hash, compact);
   endtask

   task automatic offer_random_items(int count);
      for (int i = 0; i < count; i++) offer_random_item();
   endtask

   task automatic settle_pipeline();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_limits(wide_type value);
      reg_index_type index;
      for (int i = 0; i < HASH_WORDS; i++) begin
         index = reg_index_type'(i);
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= CSR_ADDR_WIDTH'(8 * int'(index));
         pwdata  <= value[index];
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         sb.set_limit(int'(index), value[index]);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      limit_settings++;
   endtask

   task automatic offer_at_target(logic [COMPACT_WIDTH-1:0] compact, int delta);
      offer_item(sb.expand_target(compact) + HASH_WIDTH'(delta), compact);
   endtask

   initial begin
      reset                 = 1'b1;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_ch.valid          = 1'b0;
      req_ch.hash_word_0    = '0;
      req_ch.hash_word_1    = '0;
      req_ch.hash_word_2    = '0;
      req_ch.hash_word_3    = '0;
      req_ch.compact_target = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limit: field extremes and every rejection rule the all-ones limit can trigger
      offer_item('0, 32'h0000_0000);
      offer_item('1, 32'hffff_ffff);
      offer_item('1, 32'h0080_0000);
      offer_item('0, 32'h0380_0001);
      offer_at_target(32'h0212_3456, 0);
      offer_item('0, 32'h0100_0080);
      offer_at_target(32'h017f_0000, 0);
      offer_at_target(32'h017f_0000, 1);
      offer_item('0, 32'h00ff_ffff);
      offer_item('0, 32'h2300_0001);
      offer_item('1, 32'h2200_00ff);
      offer_at_target(32'h2200_00ff, 0);
      offer_item('0, 32'h2200_0100);
      offer_at_target(32'h2100_ffff, 0);
      offer_item('0, 32'h2101_0000);
      offer_at_target(32'h2001_0000, 0);
      offer_at_target(32'h207f_ffff, 0);
      offer_item('0, 32'hff7f_ffff);
      offer_at_target(32'h1d00_ffff, 1);
      settle_pipeline();

      // customary limit: target equal to it, just above it, then a long hold
      write_limits(sb.expand_target(32'h1d00_ffff));
      offer_item('0, 32'h1d00_ffff);
      offer_item('0, 32'h1d01_0000);
      hold_asked <= hold_asked + 1;
      rush_left = 30;
      offer_random_items(150);
      settle_pipeline();

      write_limits('0);
      offer_random_items(40);
      settle_pipeline();

      write_limits(random_wide() >> $urandom_range(0, 255));
      offer_random_items(75);
      calm <= 1'b1;
      offer_random_items(75);
      calm <= 1'b0;
      settle_pipeline();

      write_limits('1);
      offer_random_items(110);
      settle_pipeline();

      $display("covered %0d items and %0d results over %0d limit settings",
               sb.items_noted, sb.results_checked, limit_settings);
      $display("status mix: pass %0d, negative %0d, zero %0d, overflow %0d, %s %0d, %s %0d",
               sb.status_seen[ST_PASS], sb.status_seen[ST_NEGATIVE], sb.status_seen[ST_ZERO],
               sb.status_seen[ST_OVERFLOW], "above limit", sb.status_seen[ST_ABOVE_LIMIT],
               "hash high", sb.status_seen[ST_HASH_HIGH]);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("** pow_target_check_top: PASSED **");
      end else begin
         $display("** pow_target_check_top: FAILED **");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/ptc_pkg.sv
rtl/ptc_req_if.sv
rtl/ptc_rsp_if.sv
rtl/ptc_decode.sv
rtl/ptc_expand.sv
rtl/ptc_compare.sv
rtl/pow_target_check_top.sv
verif/tb_pow_target_check_top.sv
